>>> hdl/ecc_pkg.sv
// Shared types and constants of the elevator car controller.
package ecc_pkg;

	// Command codes carried on the mode input.
	localparam logic [2:0] MODE_TICK    = 3'd0;
	localparam logic [2:0] MODE_REQUEST = 3'd1;
	localparam logic [2:0] MODE_OPEN    = 3'd2;
	localparam logic [2:0] MODE_CLOSE   = 3'd3;
	localparam logic [2:0] MODE_STOP    = 3'd4;
	localparam logic [2:0] MODE_VENT    = 3'd5;

	// Configuration register indexes.
	localparam logic [2:0] REG_FLOOR_COUNT  = 3'd0;
	localparam logic [2:0] REG_FLOOR_HEIGHT = 3'd1;
	localparam logic [2:0] REG_CAR_SPEED    = 3'd2;
	localparam logic [2:0] REG_DOOR_RATE    = 3'd3;
	localparam logic [2:0] REG_DOOR_HOLD    = 3'd4;

	// Configuration reset values.
	localparam logic [4:0]  RST_FLOOR_COUNT  = 5'd16;
	localparam logic [19:0] RST_FLOOR_HEIGHT = 20'd196608;
	localparam logic [19:0] RST_CAR_SPEED    = 20'd131072;
	localparam logic [19:0] RST_DOOR_RATE    = 20'd117965;
	localparam logic [19:0] RST_DOOR_HOLD    = 20'd327680;

	// Door fully open, 1.0 with 16 fraction bits.
	localparam logic [16:0] DOOR_FULL = 17'h10000;

	// Car operating modes as reported on car_mode.
	typedef enum logic [2:0] {
		CM_IDLE    = 3'd0,
		CM_MOVING  = 3'd1,
		CM_STOPPED = 3'd2,
		CM_OPENING = 3'd3,
		CM_OPEN    = 3'd4,
		CM_CLOSING = 3'd5
	} car_mode_t;

	// Sequencer states.
	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_SCAN      = 6'b000010,
		ST_MUL_ISSUE = 6'b000100,
		ST_MUL_TAKE  = 6'b001000,
		ST_EXEC      = 6'b010000,
		ST_DONE      = 6'b100000
	} seq_state_t;

	// Product selected on the shared multiplier.
	typedef enum logic [1:0] {
		MS_MOVE = 2'd0,
		MS_DOOR = 2'd1,
		MS_GOAL = 2'd2
	} mul_sel_t;

endpackage

>>> hdl/ecc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ecc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hdl/elevator_car_controller.sv
// A command is searched against the queue entries (the whole fill for a floor request, the front
// entry or none otherwise); a tick then forms its three products in turn through the one shared
// multiplier. One command is handled at a time; start is taken again in the cycle after done.
// The result is on the ports for the single done cycle and the receiver cannot stall it.
// Reset (arst_n low, asynchronous) puts the car idle at floor 0 with an empty request queue.
module elevator_car_controller
	import ecc_pkg::*;
#(
	parameter int MAX_FLOORS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [3:0]  floor_index,
	input  logic [15:0] tick_time,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	output logic        done,
	output logic [2:0]  car_mode,
	output logic [3:0]  at_floor,
	output logic [3:0]  goal_floor,
	output logic [23:0] car_height,
	output logic [16:0] door_fraction,
	output logic        fan_on,
	output logic [4:0]  pending_count
);

	localparam int AW  = $clog2(MAX_FLOORS);
	localparam int FW  = $clog2(MAX_FLOORS + 1);
	localparam int SW  = FW + 1;
	localparam int LIM = (MAX_FLOORS < 16) ? MAX_FLOORS : 16;
	localparam logic [4:0]    LIM5    = 5'(LIM);
	localparam logic [FW-1:0] FILL_MAX = FW'(MAX_FLOORS);
	localparam logic [SW-1:0] DEPTH_S  = SW'(MAX_FLOORS);
	localparam logic [AW-1:0] LAST_A   = AW'(MAX_FLOORS - 1);

	// Configuration registers.
	logic [4:0]  cfg_floors_q;
	logic [19:0] cfg_height_q;
	logic [19:0] cfg_speed_q;
	logic [19:0] cfg_rate_q;
	logic [19:0] cfg_hold_q;

	// Car state.
	car_mode_t     car_mode_q;
	logic [3:0]    at_floor_q;
	logic [3:0]    goal_q;
	logic [23:0]   height_q;
	logic [16:0]   door_q;
	logic [20:0]   hold_q;
	logic          ext_q;
	logic          fan_q;
	logic [3:0]    fan_floor_q;
	logic [AW-1:0] head_q;
	logic [FW-1:0] fill_q;

	// Command and sequencer registers.
	seq_state_t    state_q;
	logic [2:0]    mode_q;
	logic [3:0]    floor_q;
	logic [15:0]   tick_q;
	logic [FW-1:0] idx_q;
	logic          pend_q;
	logic          pend_first_q;
	logic [3:0]    front_q;
	logic          found_q;
	mul_sel_t      sel_q;
	logic [35:0]   prod_q;
	logic [19:0]   mv_q;
	logic [19:0]   dd_q;
	logic [23:0]   ty_q;

	// Queue memory ports.
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [3:0]    rd_data;
	logic          wr_en;
	logic [AW-1:0] tail_addr;

	// Pop advances the head with wraparound at the queue depth.
	function automatic logic [AW-1:0] head_inc(input logic [AW-1:0] hd);
		return (hd == LAST_A) ? '0 : hd + AW'(1);
	endfunction

	// Queue slot at an offset from the head, wrapped once at the depth.
	function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] hd, input logic [FW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(hd) + SW'(off);
		if (sum >= DEPTH_S) begin
			sum = sum - DEPTH_S;
		end
		return sum[AW-1:0];
	endfunction

	// Saturate the requested floor to the served floor range.
	logic [4:0] eff_count;
	logic [3:0] top_floor;
	logic [3:0] floor_sat;

	always_comb begin
		if (cfg_floors_q == 5'd0) begin
			eff_count = 5'd1;
		end else if (cfg_floors_q > LIM5) begin
			eff_count = LIM5;
		end else begin
			eff_count = cfg_floors_q;
		end
		top_floor = 4'(eff_count - 5'd1);
		floor_sat = (floor_index > top_floor) ? top_floor : floor_index;
	end

	// The search covers the whole queue for a request, only the front otherwise.
	logic [FW-1:0] scan_n;
	logic          scan_issue;

	always_comb begin
		if (mode_q == MODE_REQUEST) begin
			scan_n = fill_q;
		end else begin
			scan_n = (fill_q != '0) ? FW'(1) : '0;
		end
		scan_issue = (state_q == ST_SCAN) && (idx_q < scan_n);
		rd_en      = scan_issue;
		rd_addr    = slot_at(head_q, idx_q);
		tail_addr  = slot_at(head_q, fill_q);
	end

	// Shared multiplier operands.
	logic [19:0] op_a;
	logic [15:0] op_b;

	always_comb begin
		unique case (sel_q)
			MS_MOVE: begin
				op_a = cfg_speed_q;
				op_b = tick_q;
			end
			MS_DOOR: begin
				op_a = cfg_rate_q;
				op_b = tick_q;
			end
			MS_GOAL: begin
				op_a = cfg_height_q;
				op_b = {12'd0, goal_q};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Next car state for the command being executed.
	car_mode_t     nx_mode;
	logic [3:0]    nx_at;
	logic [3:0]    nx_goal;
	logic [23:0]   nx_height;
	logic [16:0]   nx_door;
	logic [20:0]   nx_hold;
	logic          nx_ext;
	logic          nx_fan;
	logic [3:0]    nx_fan_floor;
	logic [AW-1:0] nx_head;
	logic [FW-1:0] nx_fill;
	logic          push;

	always_comb begin
		logic [24:0] up_sum;
		logic [23:0] down_gap;
		logic [20:0] door_sum;
		logic [3:0]  first;
		logic        do_arrive;
		logic        do_start;

		nx_mode      = car_mode_q;
		nx_at        = at_floor_q;
		nx_goal      = goal_q;
		nx_height    = height_q;
		nx_door      = door_q;
		nx_hold      = hold_q;
		nx_ext       = ext_q;
		nx_fan       = fan_q;
		nx_fan_floor = fan_floor_q;
		nx_head      = head_q;
		nx_fill      = fill_q;
		push         = 1'b0;
		up_sum       = {1'b0, height_q} + 25'(mv_q);
		down_gap     = height_q - ty_q;
		door_sum     = {4'd0, door_q} + {1'b0, dd_q};
		first        = front_q;
		do_arrive    = 1'b0;
		do_start     = 1'b0;

		unique case (mode_q)
			MODE_TICK: begin
				if (tick_q != '0) begin
					unique case (car_mode_q)
						CM_IDLE: begin
							if (door_q == '0 && fill_q != '0) begin
								do_start = 1'b1;
							end
						end
						CM_MOVING: begin
							if (ty_q > height_q) begin
								if (up_sum >= {1'b0, ty_q}) begin
									do_arrive = 1'b1;
								end else begin
									nx_height = up_sum[23:0];
								end
							end else if ({4'd0, mv_q} >= down_gap) begin
								do_arrive = 1'b1;
							end else begin
								nx_height = height_q - 24'(mv_q);
							end
						end
						CM_OPENING: begin
							if (door_sum >= 21'(DOOR_FULL)) begin
								nx_door = DOOR_FULL;
								nx_hold = {1'b0, cfg_hold_q};
								nx_ext  = 1'b0;
								nx_mode = CM_OPEN;
							end else begin
								nx_door = door_sum[16:0];
							end
						end
						CM_OPEN: begin
							if ({5'd0, tick_q} >= hold_q) begin
								nx_hold = '0;
								nx_mode = CM_CLOSING;
							end else begin
								nx_hold = hold_q - 21'(tick_q);
							end
						end
						CM_CLOSING: begin
							if (dd_q >= {3'd0, door_q}) begin
								nx_door  = '0;
								nx_mode  = CM_IDLE;
								do_start = 1'b1;
							end else begin
								nx_door = door_q - 17'(dd_q);
							end
						end
						default: begin
						end
					endcase
				end
			end
			MODE_REQUEST: begin
				if (floor_q == goal_q && (car_mode_q == CM_MOVING || car_mode_q == CM_STOPPED)) begin
				end else if (found_q) begin
				end else if (car_mode_q == CM_IDLE && floor_q == at_floor_q && door_q == '0) begin
					nx_mode = CM_OPENING;
				end else if (fill_q < FILL_MAX) begin
					push    = 1'b1;
					nx_fill = fill_q + FW'(1);
					if (fill_q == '0) begin
						first = floor_q;
					end
					if (car_mode_q == CM_IDLE && door_q == '0) begin
						do_start = 1'b1;
					end
				end
			end
			MODE_OPEN: begin
				if (car_mode_q == CM_OPEN && !ext_q) begin
					nx_hold = hold_q + {1'b0, cfg_hold_q};
					nx_ext  = 1'b1;
				end
			end
			MODE_CLOSE: begin
				if (car_mode_q == CM_OPEN) begin
					nx_hold = '0;
				end
				if (car_mode_q == CM_OPENING) begin
					nx_mode = CM_CLOSING;
				end
			end
			MODE_STOP: begin
				if (car_mode_q == CM_MOVING) begin
					nx_mode = CM_STOPPED;
				end else if (car_mode_q == CM_STOPPED) begin
					nx_mode = CM_MOVING;
				end
			end
			MODE_VENT: begin
				nx_fan = !fan_q;
				if (!fan_q) begin
					if (car_mode_q == CM_MOVING || car_mode_q == CM_STOPPED) begin
						nx_fan_floor = goal_q;
					end else if (fill_q != '0) begin
						nx_fan_floor = front_q;
					end else begin
						nx_fan_floor = at_floor_q;
					end
				end
			end
			default: begin
			end
		endcase

		// Arrival: snap to the goal height, drop the goal from the front, open.
		if (do_arrive) begin
			nx_height = ty_q;
			nx_at     = goal_q;
			if (fill_q != '0 && front_q == goal_q) begin
				nx_head = head_inc(head_q);
				nx_fill = fill_q - FW'(1);
			end
			if (fan_q && goal_q == fan_floor_q) begin
				nx_fan = 1'b0;
			end
			nx_mode = CM_OPENING;
		end

		// Start the next queued move, open at once if it is this floor, or go idle if the queue is empty.
		if (do_start) begin
			if (nx_fill != '0 && first == at_floor_q) begin
				nx_head = head_inc(head_q);
				nx_fill = nx_fill - FW'(1);
				nx_mode = CM_OPENING;
			end else if (nx_fill == '0) begin
				nx_mode = CM_IDLE;
			end else begin
				nx_goal = first;
				nx_mode = CM_MOVING;
			end
		end
	end

	assign wr_en = (state_q == ST_EXEC) && push;

	// Request queue storage.
	ecc_ram #(
		.WIDTH(4),
		.DEPTH(MAX_FLOORS)
	) u_queue (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(tail_addr),
		.wr_data(floor_q),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Configuration writes.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_floors_q <= RST_FLOOR_COUNT;
			cfg_height_q <= RST_FLOOR_HEIGHT;
			cfg_speed_q  <= RST_CAR_SPEED;
			cfg_rate_q   <= RST_DOOR_RATE;
			cfg_hold_q   <= RST_DOOR_HOLD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FLOOR_COUNT:  cfg_floors_q <= cfg_data[4:0];
				REG_FLOOR_HEIGHT: cfg_height_q <= cfg_data;
				REG_CAR_SPEED:    cfg_speed_q  <= cfg_data;
				REG_DOOR_RATE:    cfg_rate_q   <= cfg_data;
				REG_DOOR_HOLD:    cfg_hold_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Command sequencer: accept, search the queue, form products for a tick, execute, report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			pend_q       <= 1'b0;
			pend_first_q <= 1'b0;
			found_q      <= 1'b0;
			sel_q        <= MS_MOVE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q   <= '0;
						pend_q  <= 1'b0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					pend_q       <= scan_issue;
					pend_first_q <= (idx_q == '0);
					if (scan_issue) begin
						idx_q <= idx_q + FW'(1);
					end
					if (pend_q && rd_data == floor_q) begin
						found_q <= 1'b1;
					end
					if (!scan_issue) begin
						sel_q   <= MS_MOVE;
						state_q <= (mode_q == MODE_TICK) ? ST_MUL_ISSUE : ST_EXEC;
					end
				end
				ST_MUL_ISSUE: begin
					state_q <= ST_MUL_TAKE;
				end
				ST_MUL_TAKE: begin
					if (sel_q == MS_GOAL) begin
						state_q <= ST_EXEC;
					end else begin
						sel_q   <= (sel_q == MS_MOVE) ? MS_DOOR : MS_GOAL;
						state_q <= ST_MUL_ISSUE;
					end
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command payload, front entry and products.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			mode_q  <= mode;
			floor_q <= floor_sat;
			tick_q  <= tick_time;
		end
		if (state_q == ST_SCAN && pend_q && pend_first_q) begin
			front_q <= rd_data;
		end
		if (state_q == ST_MUL_ISSUE) begin
			prod_q <= {16'd0, op_a} * {20'd0, op_b};
		end
		if (state_q == ST_MUL_TAKE) begin
			unique case (sel_q)
				MS_MOVE: mv_q <= prod_q[35:16];
				MS_DOOR: dd_q <= prod_q[35:16];
				MS_GOAL: ty_q <= prod_q[23:0];
				default: begin
				end
			endcase
		end
	end

	// Car state update at the execute step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			car_mode_q  <= CM_IDLE;
			at_floor_q  <= '0;
			goal_q      <= '0;
			height_q    <= '0;
			door_q      <= '0;
			hold_q      <= '0;
			ext_q       <= 1'b0;
			fan_q       <= 1'b0;
			fan_floor_q <= '0;
			head_q      <= '0;
			fill_q      <= '0;
		end else if (state_q == ST_EXEC) begin
			car_mode_q  <= nx_mode;
			at_floor_q  <= nx_at;
			goal_q      <= nx_goal;
			height_q    <= nx_height;
			door_q      <= nx_door;
			hold_q      <= nx_hold;
			ext_q       <= nx_ext;
			fan_q       <= nx_fan;
			fan_floor_q <= nx_fan_floor;
			head_q      <= nx_head;
			fill_q      <= nx_fill;
		end
	end

	// Result ports show the state after the command during the done cycle.
	assign busy          = (state_q != ST_IDLE);
	assign done          = (state_q == ST_DONE);
	assign car_mode      = car_mode_q;
	assign at_floor      = at_floor_q;
	assign goal_floor    = goal_q;
	assign car_height    = height_q;
	assign door_fraction = door_q;
	assign fan_on        = fan_q;
	assign pending_count = 5'(fill_q);

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("request queue fill exceeds its depth");

	a_open_door: assert property (@(posedge clk) disable iff (!arst_n)
		(car_mode_q == CM_OPEN) |-> (door_q == DOOR_FULL))
		else $error("car reports doors open while they are not fully open");

	a_idle_door: assert property (@(posedge clk) disable iff (!arst_n)
		(car_mode_q == CM_IDLE) |-> (door_q == '0))
		else $error("car idle with doors not closed");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_SCAN))
		else $error("accepted command did not enter the queue search");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after reporting a result");
`endif

endmodule
